/* rtl/core/oaht_pkg.sv */
// Shared types, codes and the control store of the open-addressing hash table.
// Holds the microcode program read by oaht_seq and the control structs passed
// to oaht_dp. Depends on nothing.
package oaht_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int SLOT_W    = 4;
  localparam int SIZE_W    = 5;
  localparam int MAX_SIZE  = (1 << SIZE_W) - 1;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = KEY_W / DIV_BITS;
  localparam int PC_W      = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Request modes; any other code is treated as a search
  localparam logic [MODE_W-1:0] MODE_INS_LIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INS_QUAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING  = 2'd3;

  typedef logic [PC_W-1:0] pc_t;

  // Microprogram addresses
  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_DIV  = 4'd1;
  localparam pc_t PC_HOME = 4'd2;
  localparam pc_t PC_READ = 4'd3;
  localparam pc_t PC_TEST = 4'd4;
  localparam pc_t PC_MISS = 4'd5;
  localparam pc_t PC_FAIL = 4'd6;
  localparam pc_t PC_HIT  = 4'd7;
  localparam pc_t PC_OUT  = 4'd8;

  // Branch conditions tested by the sequencer
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_DIV_LAST,
    C_HIT,
    C_LAST,
    C_OUT_BUSY
  } cond_t;

  // Datapath operations, one bit each
  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_home;
    logic mem_read;
    logic advance;
    logic set_fail;
    logic set_hit;
    logic out_load;
  } ctrl_t;

  // Status returned from the datapath to the sequencer
  typedef struct packed {
    logic div_last;
    logic hit;
    logic last;
    logic out_busy;
  } flags_t;

  // One control word: branch on cond to t_true, else to t_false
  typedef struct packed {
    cond_t cond;
    pc_t   t_true;
    pc_t   t_false;
    ctrl_t ops;
  } uword_t;

  // Control store
  function automatic uword_t ucode_word(input pc_t pc);
    uword_t w;
    w         = '0;
    w.cond    = C_ALWAYS;
    w.t_true  = PC_IDLE;
    w.t_false = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.cond = C_IN_VALID; w.t_true = PC_DIV; w.t_false = PC_IDLE;
        w.ops.accept = 1'b1;
      end
      PC_DIV: begin
        w.cond = C_DIV_LAST; w.t_true = PC_HOME; w.t_false = PC_DIV;
        w.ops.div_step = 1'b1;
      end
      PC_HOME: begin
        w.t_true = PC_READ; w.t_false = PC_READ;
        w.ops.load_home = 1'b1;
      end
      PC_READ: begin
        w.t_true = PC_TEST; w.t_false = PC_TEST;
        w.ops.mem_read = 1'b1;
      end
      PC_TEST: begin
        w.cond = C_HIT; w.t_true = PC_HIT; w.t_false = PC_MISS;
      end
      PC_MISS: begin
        w.cond = C_LAST; w.t_true = PC_FAIL; w.t_false = PC_READ;
        w.ops.advance = 1'b1;
      end
      PC_FAIL: begin
        w.t_true = PC_OUT; w.t_false = PC_OUT;
        w.ops.set_fail = 1'b1;
      end
      PC_HIT: begin
        w.t_true = PC_OUT; w.t_false = PC_OUT;
        w.ops.set_hit = 1'b1;
      end
      PC_OUT: begin
        w.cond = C_OUT_BUSY; w.t_true = PC_OUT; w.t_false = PC_IDLE;
        w.ops.out_load = 1'b1;
      end
      default: begin
        w.t_true = PC_IDLE; w.t_false = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/oaht_div.sv */
// Remainder unit: key mod table size, four quotient digits per cycle while step is high.
// Runs under the sequencer's div_step control. Depends on oaht_pkg.
module oaht_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          step,
  input  logic [oaht_pkg::KEY_W-1:0]    key,
  input  logic [oaht_pkg::SIZE_W-1:0]   size,
  output logic [oaht_pkg::SIZE_W-1:0]   rem,
  output logic                          last
);

  localparam int CW = $clog2(oaht_pkg::DIV_STEPS);

  logic [oaht_pkg::KEY_W-1:0]  sh_r;
  logic [oaht_pkg::SIZE_W-1:0] rem_r;
  logic [oaht_pkg::SIZE_W-1:0] rem_nxt;
  logic [CW-1:0]               cnt_r;

  // Shift in the next digits, restoring subtract after each bit
  always_comb begin
    logic [oaht_pkg::SIZE_W:0]   t;
    logic [oaht_pkg::SIZE_W-1:0] r;
    r = rem_r;
    for (int k = 0; k < oaht_pkg::DIV_BITS; k++) begin
      t = {r, sh_r[oaht_pkg::KEY_W-1-k]};
      if (t >= {1'b0, size}) begin
        t = t - {1'b0, size};
      end
      r = t[oaht_pkg::SIZE_W-1:0];
    end
    rem_nxt = r;
  end

  // Digit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Dividend shifter and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= key;
      rem_r <= '0;
    end else if (step) begin
      sh_r  <= sh_r << oaht_pkg::DIV_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r;
  assign last = (cnt_r == CW'(oaht_pkg::DIV_STEPS - 1));

endmodule

/* rtl/core/oaht_seq.sv */
// Microcode sequencer: step counter, control store lookup and branch select.
// Drives the datapath through ctrl_t. Depends on oaht_pkg.
module oaht_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  oaht_pkg::flags_t flags,
  output oaht_pkg::ctrl_t  ctrl
);

  oaht_pkg::pc_t    pc_r;
  oaht_pkg::pc_t    pc_nxt;
  oaht_pkg::uword_t word;
  logic             cond_true;

  assign word = oaht_pkg::ucode_word(pc_r);

  // Select the branch condition
  always_comb begin
    case (word.cond)
      oaht_pkg::C_ALWAYS:   cond_true = 1'b1;
      oaht_pkg::C_IN_VALID: cond_true = in_valid;
      oaht_pkg::C_DIV_LAST: cond_true = flags.div_last;
      oaht_pkg::C_HIT:      cond_true = flags.hit;
      oaht_pkg::C_LAST:     cond_true = flags.last;
      oaht_pkg::C_OUT_BUSY: cond_true = flags.out_busy;
      default:              cond_true = 1'b0;
    endcase
    pc_nxt = cond_true ? word.t_true : word.t_false;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= oaht_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl = word.ops;

endmodule

/* rtl/core/oaht_dp.sv */
// Datapath: request and size registers, probe arithmetic, slot storage and
// the result and output registers. Uses oaht_div; depends on oaht_pkg.
module oaht_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  oaht_pkg::ctrl_t               ctrl,
  input  logic                          in_valid,
  input  logic [oaht_pkg::MODE_W-1:0]   in_mode,
  input  logic [oaht_pkg::KEY_W-1:0]    in_key,
  input  logic [oaht_pkg::VAL_W-1:0]    in_value,
  input  logic                          cfg_valid,
  input  logic [oaht_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                          out_ready,
  output oaht_pkg::flags_t              flags,
  output logic                          out_valid,
  output logic [oaht_pkg::STAT_W-1:0]   out_status,
  output logic [oaht_pkg::SLOT_W-1:0]   out_slot,
  output logic [oaht_pkg::VAL_W-1:0]    out_value
);

  // Slots at or above the largest programmable size are never reached
  localparam int DEPTH = (ENTRIES < oaht_pkg::MAX_SIZE) ? ENTRIES : oaht_pkg::MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = oaht_pkg::SIZE_W;

  logic [SW-1:0]                size_cfg_r;
  logic [SW-1:0]                size;
  logic [oaht_pkg::MODE_W-1:0]  mode_r;
  logic [oaht_pkg::KEY_W-1:0]   key_r;
  logic [oaht_pkg::VAL_W-1:0]   val_r;
  logic [SW-1:0]                p_r;
  logic [SW-1:0]                d_r;
  logic [SW-1:0]                i_r;
  logic [SW-1:0]                p_nxt;
  logic [SW-1:0]                d_nxt;
  logic [SW-1:0]                rem;
  logic                         div_last;
  logic [AW-1:0]                idx;
  logic                         is_ins;
  logic                         is_quad;
  logic                         cap;
  logic                         out_busy;
  logic                         out_load;
  logic [DEPTH-1:0]             used_r;
  logic [oaht_pkg::KEY_W-1:0]   keys_mem [DEPTH];
  logic [oaht_pkg::VAL_W-1:0]   vals_mem [DEPTH];
  logic [oaht_pkg::KEY_W-1:0]   key_rd_r;
  logic [oaht_pkg::VAL_W-1:0]   val_rd_r;
  logic [oaht_pkg::STAT_W-1:0]  res_status_r;
  logic [oaht_pkg::SLOT_W-1:0]  res_slot_r;
  logic [oaht_pkg::VAL_W-1:0]   res_val_r;
  logic                         out_valid_r;
  logic [oaht_pkg::STAT_W-1:0]  out_status_r;
  logic [oaht_pkg::SLOT_W-1:0]  out_slot_r;
  logic [oaht_pkg::VAL_W-1:0]   out_val_r;

  assign cap      = ctrl.accept && in_valid;
  assign is_ins   = (mode_r == oaht_pkg::MODE_INS_LIN) || (mode_r == oaht_pkg::MODE_INS_QUAD);
  assign is_quad  = (mode_r == oaht_pkg::MODE_INS_QUAD);
  assign idx      = p_r[AW-1:0];
  assign out_busy = out_valid_r && !out_ready;
  assign out_load = ctrl.out_load && !out_busy;

  // Size register; the user must write it only while the sequencer idles, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= oaht_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      size_cfg_r <= cfg_data;
    end
  end

  // Clamp the programmed size to 1 .. DEPTH
  always_comb begin
    if (size_cfg_r == '0) begin
      size = SW'(1);
    end else if (size_cfg_r > SW'(DEPTH)) begin
      size = SW'(DEPTH);
    end else begin
      size = size_cfg_r;
    end
  end

  // Capture the request transaction
  always_ff @(posedge clk) begin
    if (cap) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      val_r  <= in_value;
    end
  end

  // The divider loads the key in the accept cycle, straight from the port
  oaht_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cap),
    .step  (ctrl.div_step),
    .key   (in_key),
    .size  (size),
    .rem   (rem),
    .last  (div_last)
  );

  assign flags.div_last = div_last;

  // Next probe: p + d and (d + 2) for quadratic steps, both mod size
  always_comb begin
    logic [SW:0] ps;
    logic [SW:0] ds;
    ps = {1'b0, p_r} + {1'b0, d_r};
    if (ps >= {1'b0, size}) begin
      ps = ps - {1'b0, size};
    end
    p_nxt = ps[SW-1:0];
    ds = {1'b0, d_r} + (SW+1)'(2);
    if (ds >= {1'b0, size}) begin
      ds = ds - {1'b0, size};
    end
    if (ds >= {1'b0, size}) begin
      ds = ds - {1'b0, size};
    end
    d_nxt = is_quad ? ds[SW-1:0] : d_r;
  end

  // Probe position, step and probe count
  always_ff @(posedge clk) begin
    if (ctrl.load_home) begin
      p_r <= rem;
      d_r <= (size == SW'(1)) ? SW'(0) : SW'(1);
      i_r <= '0;
    end else if (ctrl.advance) begin
      p_r <= p_nxt;
      d_r <= d_nxt;
      i_r <= i_r + 1'b1;
    end
  end

  assign flags.last     = (i_r == size - 1'b1);
  assign flags.hit      = is_ins ? !used_r[idx] : (used_r[idx] && (key_rd_r == key_r));
  assign flags.out_busy = out_busy;

  // Slot storage: registered read, write on an insert hit
  always_ff @(posedge clk) begin
    if (ctrl.mem_read) begin
      key_rd_r <= keys_mem[idx];
      val_rd_r <= vals_mem[idx];
    end
    if (ctrl.set_hit && is_ins) begin
      keys_mem[idx] <= key_r;
      vals_mem[idx] <= val_r;
    end
  end

  // Occupied marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctrl.set_hit && is_ins) begin
      used_r[idx] <= 1'b1;
    end
  end

  // Record the outcome of the probe walk
  always_ff @(posedge clk) begin
    if (ctrl.set_fail) begin
      res_status_r <= is_ins ? oaht_pkg::ST_FULL : oaht_pkg::ST_MISSING;
      res_slot_r   <= '0;
      res_val_r    <= '0;
    end else if (ctrl.set_hit) begin
      res_status_r <= is_ins ? oaht_pkg::ST_INSERTED : oaht_pkg::ST_FOUND;
      res_slot_r   <= p_r[oaht_pkg::SLOT_W-1:0];
      res_val_r    <= is_ins ? '0 : val_rd_r;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_val_r    <= res_val_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_value  = out_val_r;

  // An insert only ever claims an empty slot
  a_ins_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.set_hit && is_ins) |-> !used_r[idx])
    else $error("insert claimed an occupied slot");

  // Occupied marks change only on an insert hit
  a_used_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.set_hit && is_ins) |=> (used_r == $past(used_r)))
    else $error("occupied marks changed without an insert");

  // A pending result leaves only when taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("result dropped before it was taken");

endmodule

/* rtl/core/open_addressing_hash_table.sv */
// Open-addressing hash table, top level: stream channels and port packing.
// Instantiates oaht_seq and oaht_dp; depends on oaht_pkg.
//
// Usage:
//   in_*  : one request transaction, mode in in_tuser, key and value in in_tdata.
//   out_* : one result transaction per request, status in out_tuser, slot and
//           found value in out_tdata.
//   cfg_* : writes table_size (1..16 in use, 0 counts as 1); write it only
//           while no request is in flight. cfg_ready is always high.
// Timing: a request is taken in the sequencer's idle step, then the home slot
//   (key mod size) comes from a remainder unit that retires four key bits per
//   cycle. Each probe walks the memory read, test and, on a miss, advance
//   steps on the single-port slot store. A request that ends its probe walk
//   records its outcome in a hit or fail step and then loads the output
//   register. One request is in work at a time.
// Reset: all slots empty, table_size = 16, no result pending.
// Stall: a finished result waits in the output register; the sequencer holds
//   in its output step until that register is free, and accepts the next
//   request right after handing the result over.
module open_addressing_hash_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] slot, [35:4] found_value, [39:36] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // [4:0] table_size
);

  oaht_pkg::ctrl_t                ctrl;
  oaht_pkg::flags_t               flags;
  logic [oaht_pkg::STAT_W-1:0]    status;
  logic [oaht_pkg::SLOT_W-1:0]    slot;
  logic [oaht_pkg::VAL_W-1:0]     found_value;

  assign cfg_ready = 1'b1;
  assign in_tready = ctrl.accept;

  oaht_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  oaht_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_valid   (in_tvalid),
    .in_mode    (in_tuser),
    .in_key     (in_tdata[31:0]),
    .in_value   (in_tdata[63:32]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (out_tready),
    .flags      (flags),
    .out_valid  (out_tvalid),
    .out_status (status),
    .out_slot   (slot),
    .out_value  (found_value)
  );

  // Pack the result transaction
  assign out_tdata = {4'b0000, found_value, slot};
  assign out_tuser = status;

endmodule
